[sv/pct_pkg.sv]
// Shared types, status codes and constants for the piecewise-constant table.
`timescale 1ns / 1ps

package pct_pkg;

  localparam int MAX_SEGMENTS_DEF = 512;
  localparam int VAL_W = 32;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_GAP   = 3'd3;
  localparam logic [2:0] ST_UNDEF = 3'd4;

  // Request kinds
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_CMP,
    S_HREAD,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic search_rd;
    logic cmp_step;
    logic height_rd;
    logic height_take;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic query_undef;
    logic lo_lt_hi;
    logic out_free;
  } stat_t;

endpackage

[sv/piecewise_constant_table.sv]
// Top level of the piecewise-constant table: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one request: action 0 appends the
//   segment [seg_start, seg_finish) with height seg_height; action 1 looks up
//   query_point. Output channel (out_valid/out_ready) returns one result per
//   request: value_out (height for a good lookup, else zero) and status.
//   All values are signed Q16.16; comparisons are exact.
// Sequencing:
//   One request at a time. An insert goes from accept to result through
//   latch, check and write, and output load. A lookup out of range takes the
//   same path. A lookup in range runs a binary search over the stored segment
//   ends: each halving is a registered end_mem read, then a compare.
//   The search loop over the single end_mem read port dominates lookup time.
//   in_ready is high while the controller is idle, including while a result
//   still waits in the output register.
// Stall: if out_ready is low, the finished result is held; a following
//   request is worked on and parks its result until the output register frees.
// Reset: synchronous rst empties the table (segment count to zero) and
//   drops out_valid. The segment memories are not cleared; only entries
//   below the count are ever read.

module piecewise_constant_table #(
  parameter int MAX_SEGMENTS = pct_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] seg_start,
  input  logic signed [31:0] seg_finish,
  input  logic signed [31:0] seg_height,
  input  logic signed [31:0] query_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value_out,
  output logic [2:0]         status
);

  pct_pkg::cmd_t  cmd;
  pct_pkg::stat_t stat;

  // state machine: request sequencing and output hand-off
  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // segment memories, search bounds, result and output registers
  pct_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .seg_start   (seg_start),
    .seg_finish  (seg_finish),
    .seg_height  (seg_height),
    .query_point (query_point),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .value_out   (value_out),
    .status      (status)
  );

endmodule

[sv/pct_dpath.sv]
// Datapath: request registers, segment memories, search bounds and result registers.
`timescale 1ns / 1ps

module pct_dpath #(
  parameter int MAX_SEGMENTS = pct_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pct_pkg::cmd_t       cmd,
  output pct_pkg::stat_t      stat,
  input  logic                action,
  input  logic signed [31:0]  seg_start,
  input  logic signed [31:0]  seg_finish,
  input  logic signed [31:0]  seg_height,
  input  logic signed [31:0]  query_point,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  value_out,
  output logic [2:0]          status
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  // latched request
  logic               act_q;
  logic signed [31:0] start_q;
  logic signed [31:0] finish_q;
  logic signed [31:0] height_q;
  logic signed [31:0] point_q;

  // table state
  logic signed [31:0] first_start;
  logic signed [31:0] last_end;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] end_mem    [MAX_SEGMENTS];
  logic signed [31:0] height_mem [MAX_SEGMENTS];

  // search
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic [IDX_W-1:0]   mid;
  logic signed [31:0] end_rd;
  logic signed [31:0] height_rd;

  // pending result
  logic signed [31:0] res_value;
  logic [2:0]         res_status;

  logic               full;
  logic               empty;
  logic               gap;
  logic               ins_ok;
  logic [2:0]         ins_status;
  logic               undef;
  logic [CNT_W-1:0]   cnt_m1;

  assign full   = (count == CNT_W'(MAX_SEGMENTS));
  assign empty  = (start_q >= finish_q);
  assign gap    = (count != '0) && (start_q != last_end);
  assign ins_ok = !full && !empty && !gap;
  assign undef  = (count == '0) || (point_q < first_start) || (point_q >= last_end);
  assign cnt_m1 = count - CNT_W'(1);
  assign mid    = lo + ((hi - lo) >> 1);

  // full beats empty beats gap
  always_comb begin
    if (full) begin
      ins_status = pct_pkg::ST_FULL;
    end else if (empty) begin
      ins_status = pct_pkg::ST_EMPTY;
    end else if (gap) begin
      ins_status = pct_pkg::ST_GAP;
    end else begin
      ins_status = pct_pkg::ST_OK;
    end
  end

  assign stat.is_query    = (act_q == pct_pkg::ACT_QUERY);
  assign stat.query_undef = undef;
  assign stat.lo_lt_hi    = (lo < hi);
  assign stat.out_free    = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec && act_q == pct_pkg::ACT_INSERT && ins_ok) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // first_start reads as zero after reset, but is only used once count is nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      first_start <= '0;
    end else if (cmd.exec && act_q == pct_pkg::ACT_INSERT && ins_ok && count == '0) begin
      first_start <= start_q;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_q    <= action;
      start_q  <= seg_start;
      finish_q <= seg_finish;
      height_q <= seg_height;
      point_q  <= query_point;
    end
    if (cmd.exec) begin
      res_value <= '0;
      if (act_q == pct_pkg::ACT_INSERT) begin
        res_status <= ins_status;
        if (ins_ok) begin
          last_end <= finish_q;
        end
      end else begin
        res_status <= undef ? pct_pkg::ST_UNDEF : pct_pkg::ST_OK;
        lo         <= '0;
        hi         <= cnt_m1[IDX_W-1:0];
      end
    end
    if (cmd.cmp_step) begin
      if (end_rd > point_q) begin
        hi <= mid;
      end else begin
        lo <= mid + IDX_W'(1);
      end
    end
    if (cmd.height_take) begin
      res_value  <= height_rd;
      res_status <= pct_pkg::ST_OK;
    end
    if (cmd.load_out) begin
      value_out <= res_value;
      status    <= res_status;
    end
  end

  // segment memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.exec && act_q == pct_pkg::ACT_INSERT && ins_ok) begin
      end_mem[count[IDX_W-1:0]]    <= finish_q;
      height_mem[count[IDX_W-1:0]] <= height_q;
    end
    if (cmd.search_rd) begin
      end_rd <= end_mem[mid];
    end
    if (cmd.height_rd) begin
      height_rd <= height_mem[lo];
    end
  end

endmodule

[sv/pct_ctrl.sv]
// Controller: sequences insert, range check, binary search and result hand-off.
`timescale 1ns / 1ps

module pct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pct_pkg::stat_t  stat,
  output pct_pkg::cmd_t   cmd
);

  pct_pkg::state_t state;
  pct_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pct_pkg::S_IDLE: begin
        if (in_valid) state_next = pct_pkg::S_EXEC;
      end
      pct_pkg::S_EXEC: begin
        if (!stat.is_query || stat.query_undef) begin
          state_next = pct_pkg::S_FINISH;
        end else begin
          state_next = pct_pkg::S_SEARCH;
        end
      end
      pct_pkg::S_SEARCH: begin
        state_next = stat.lo_lt_hi ? pct_pkg::S_CMP : pct_pkg::S_HREAD;
      end
      pct_pkg::S_CMP:   state_next = pct_pkg::S_SEARCH;
      pct_pkg::S_HREAD: state_next = pct_pkg::S_FINISH;
      pct_pkg::S_FINISH: begin
        if (stat.out_free) state_next = pct_pkg::S_IDLE;
      end
      default: state_next = pct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      pct_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      pct_pkg::S_EXEC:   cmd.exec = 1'b1;
      pct_pkg::S_SEARCH: begin
        cmd.search_rd = stat.lo_lt_hi;
        cmd.height_rd = !stat.lo_lt_hi;
      end
      pct_pkg::S_CMP:    cmd.cmp_step = 1'b1;
      pct_pkg::S_HREAD:  cmd.height_take = 1'b1;
      pct_pkg::S_FINISH: cmd.load_out = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
